@@ hdl/clug_pkg.sv @@
// ----------------------------------------------------------------------------
// clug_pkg
// Shared types and constants for the combined LCG uniform random block.
// ----------------------------------------------------------------------------
package clug_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAC_SHIFT = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_MUL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_INC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_MUL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_INC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_SEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEC_SEED  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_SEED = 3'd7;

  localparam logic KIND_COMBINED = 1'b0;
  localparam logic KIND_SINGLE   = 1'b1;

  // reset values
  localparam logic [WORD_W-1:0] RST_MAIN_MUL  = 32'd1664525;
  localparam logic [WORD_W-1:0] RST_MAIN_INC  = 32'd1013904223;
  localparam logic [WORD_W-1:0] RST_SEC_MUL   = 32'd69069;
  localparam logic [WORD_W-1:0] RST_SEC_INC   = 32'd3;
  localparam logic [WORD_W-1:0] RST_MAIN_SEED = 32'd0;
  localparam logic [WORD_W-1:0] RST_SEC_SEED  = 32'd1;
  localparam logic [WORD_W-1:0] RST_SKIP_SEED = 32'd1;

  // request to the shared multiply-add unit
  typedef struct packed {
    logic              issue;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] mult;
    logic [WORD_W-1:0] incr;
  } mul_req_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SEC0 = 5'b00010,
    S_MAIN1 = 5'b00100,
    S_SEC1 = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // combined-mode part: (diff >> 8) | 1, moved back into the top 24 bits
  function automatic logic [WORD_W-1:0] frac24(input logic [WORD_W-1:0] diff);
    return {diff[WORD_W-1:FRAC_SHIFT+1], 1'b1, {FRAC_SHIFT{1'b0}}};
  endfunction

endpackage

@@ hdl/combined_lcg_uniform_random.sv @@
// ----------------------------------------------------------------------------
// combined_lcg_uniform_random
// Complex uniform random pair generator, one or two 32-bit LCGs on one
// shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: an accepted request passes S_SEC0, S_MAIN1, S_SEC1 and S_FIN, where
//   the result beat is loaded; in_ready is high only in S_IDLE. Four LCG steps go one
//   after another through the single multiply-add unit (two of them idle in single mode).
// Reset: synchronous, active low; config registers take their reset values and
//   generator state loads from the seed reset values. No clearing pass.
module combined_lcg_uniform_random (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [clug_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [clug_pkg::WORD_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_last_of_vector,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [clug_pkg::WORD_W-1:0]        out_real_fraction,
  output logic [clug_pkg::WORD_W-1:0]        out_imag_fraction,
  output logic                               out_last_out
);
  import clug_pkg::*;

  logic              kind_r;
  logic [WORD_W-1:0] main_mul_r, main_inc_r, sec_mul_r, sec_inc_r;
  logic [WORD_W-1:0] main_r, sec_r, skip_r;
  logic [WORD_W-1:0] sec_nxt, skip_nxt;
  logic [WORD_W-1:0] real_r, part;
  logic              last_r;
  logic [WORD_W-1:0] out_real_r, out_imag_r;
  logic              out_last_r, out_valid_r;
  state_t            state_r, state_nxt;
  mul_req_t          req;
  logic [WORD_W-1:0] mul_res;
  logic              accept, fin_go;

  clug_mul_unit u_mul (
    .clk    (clk),
    .req    (req),
    .result (mul_res)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // issue main steps on accept and in MAIN1, second steps in SEC0/SEC1 in combined mode
  always_comb begin
    req.issue = 1'b0;
    req.value = main_r;
    req.mult  = main_mul_r;
    req.incr  = main_inc_r;
    unique case (state_r)
      S_IDLE:  req.issue = accept;
      S_MAIN1: req.issue = 1'b1;
      S_SEC0, S_SEC1: begin
        req.issue = (kind_r == KIND_COMBINED);
        req.value = sec_r;
        req.mult  = sec_mul_r;
        req.incr  = sec_inc_r;
      end
      S_FIN: req.issue = 1'b0;
      default: req.issue = 1'b0;
    endcase
  end

  // skip marker check on the freshly stepped second generator, and the output part
  always_comb begin
    if (mul_res == skip_r) begin
      sec_nxt  = mul_res + WORD_W'(1);
      skip_nxt = skip_r + WORD_W'(1);
    end else begin
      sec_nxt  = mul_res;
      skip_nxt = skip_r;
    end
    part = (kind_r == KIND_SINGLE) ? main_r : frac24(main_r - mul_res);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SEC0;
      S_SEC0:  state_nxt = S_MAIN1;
      S_MAIN1: state_nxt = S_SEC1;
      S_SEC1:  state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_COMBINED;
      main_mul_r  <= RST_MAIN_MUL;
      main_inc_r  <= RST_MAIN_INC;
      sec_mul_r   <= RST_SEC_MUL;
      sec_inc_r   <= RST_SEC_INC;
      main_r      <= RST_MAIN_SEED;
      sec_r       <= RST_SEC_SEED;
      skip_r      <= RST_SKIP_SEED;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // main result lands the cycle after each main issue
      if (state_r == S_SEC0 || state_r == S_SEC1) begin
        main_r <= mul_res;
      end
      if (kind_r == KIND_COMBINED && (state_r == S_MAIN1 || fin_go)) begin
        sec_r  <= sec_nxt;
        skip_r <= skip_nxt;
      end

      // seed writes reload the generator state at once
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KIND:      kind_r     <= cfg_wdata[0];
          REG_MAIN_MUL:  main_mul_r <= cfg_wdata;
          REG_MAIN_INC:  main_inc_r <= cfg_wdata;
          REG_SEC_MUL:   sec_mul_r  <= cfg_wdata;
          REG_SEC_INC:   sec_inc_r  <= cfg_wdata;
          REG_MAIN_SEED: main_r     <= cfg_wdata;
          REG_SEC_SEED:  sec_r      <= cfg_wdata;
          REG_SKIP_SEED: skip_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last_of_vector;
    end
    if (state_r == S_MAIN1) begin
      real_r <= part;
    end
    if (fin_go) begin
      out_real_r <= real_r;
      out_imag_r <= part;
      out_last_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_real_fraction = out_real_r;
  assign out_imag_fraction = out_imag_r;
  assign out_last_out      = out_last_r;

  a_single_holds_second: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == KIND_SINGLE && !cfg_we) |=> ($stable(sec_r) && $stable(skip_r)))
    else $error("second generator moved in single mode");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SEC0))
    else $error("accepted beat did not start the sequence");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result beat raised outside the final step");

endmodule

@@ hdl/clug_mul_unit.sv @@
// ----------------------------------------------------------------------------
// clug_mul_unit
// Shared LCG step unit: registered 32x32 low product, then add increment.
// ----------------------------------------------------------------------------
module clug_mul_unit (
  input  logic                     clk,
  input  clug_pkg::mul_req_t       req,
  output logic [clug_pkg::WORD_W-1:0] result
);
  import clug_pkg::*;

  logic [WORD_W-1:0] prod_r;
  logic [WORD_W-1:0] incr_r;
  logic [WORD_W-1:0] prod_full;

  // only the low word of the product is needed (mod 2^32)
  assign prod_full = req.value * req.mult;

  // holds its operands until the next issue, so a stalled sequencer sees a stable result
  always_ff @(posedge clk) begin
    if (req.issue) begin
      prod_r <= prod_full;
      incr_r <= req.incr;
    end
  end

  assign result = prod_r + incr_r;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for combined_lcg_uniform_random. A short directed
// table (extreme multipliers and increments, both generator modes, skip
// marker hits and wrap, reseeding, mode changes) is followed by random
// vector requests under random register settings. Each result beat is checked
// against a local model of the two LCGs or a typed-in pair; three back-pressure phases.
// ----------------------------------------------------------------------------
module tb_top;
  import clug_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SEGMENTS    = 17;
  localparam int SEG_ITEMS   = 50;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [WORD_W-1:0]     data;
    logic                  last;
    logic                  lit;   // expected pair typed in below
    logic [WORD_W-1:0]     re;
    logic [WORD_W-1:0]     im;
  } stim_row_t;

  typedef struct packed {
    logic [WORD_W-1:0] re;
    logic [WORD_W-1:0] im;
    logic              last;
  } pair_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_last_of_vector;
  logic                 out_valid;
  logic                 out_ready;
  logic [WORD_W-1:0]    out_real_fraction;
  logic [WORD_W-1:0]    out_imag_fraction;
  logic                 out_last_out;

  // generator model: registers and state
  logic              gen_kind;
  logic [WORD_W-1:0] mul_main, inc_main, mul_sec, inc_sec;
  logic [WORD_W-1:0] lcg_main, lcg_sec, skip_mark;

  stim_row_t directed_rows[$];
  pair_t     pending_pairs[$];
  int        fail_count    = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_cycles  = 0;

  combined_lcg_uniform_random u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_last_of_vector (in_last_of_vector),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_real_fraction (out_real_fraction),
    .out_imag_fraction (out_imag_fraction),
    .out_last_out      (out_last_out)
  );

  always #5 clk = ~clk;

  // one part of the pair; steps the model state
  function automatic logic [WORD_W-1:0] draw_fraction();
    logic [WORD_W-1:0] diff;
    lcg_main = lcg_main * mul_main + inc_main;
    if (gen_kind == KIND_SINGLE) return lcg_main;
    lcg_sec = lcg_sec * mul_sec + inc_sec;
    diff = lcg_main - lcg_sec;
    if (lcg_sec == skip_mark) begin
      lcg_sec   = lcg_sec + 1;
      skip_mark = skip_mark + 1;
    end
    return ((diff >> FRAC_SHIFT) | 32'h1) << FRAC_SHIFT;
  endfunction

  function automatic pair_t predict_pair(input logic last);
    pair_t p;
    p.re   = draw_fraction();
    p.im   = draw_fraction();
    p.last = last;
    return p;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    directed_rows.push_back(r);
  endtask

  task automatic add_item(input logic last, input logic lit,
                          input logic [WORD_W-1:0] re, input logic [WORD_W-1:0] im);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.last = last;
    r.lit  = lit;
    r.re   = re;
    r.im   = im;
    directed_rows.push_back(r);
  endtask

  // stop sending and let every outstanding pair come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_pairs.size() != 0) @(negedge clk);
  endtask

  // called at a falling edge with the block idle; returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_KIND:      gen_kind = data[0];
      REG_MAIN_MUL:  mul_main = data;
      REG_MAIN_INC:  inc_main = data;
      REG_SEC_MUL:   mul_sec  = data;
      REG_SEC_INC:   inc_sec  = data;
      REG_MAIN_SEED: lcg_main = data;
      REG_SEC_SEED:  lcg_sec  = data;
      REG_SKIP_SEED: skip_mark = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_item(input logic last, input logic lit, input pair_t lit_pair);
    pair_t p;
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_last_of_vector <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_pair(last);
    pending_pairs.push_back(lit ? lit_pair : p);
    @(negedge clk);
  endtask

  task automatic random_config();
    int                sel;
    logic [WORD_W-1:0] s;
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 1)) write_reg(i[CFG_IDX_W-1:0], pick_word());
    end
    sel = $urandom_range(0, 3);
    if (sel == 0) begin
      // second generator parked on the marker: a skip on every combined part
      s = pick_word();
      write_reg(REG_SEC_MUL, 32'd1);
      write_reg(REG_SEC_INC, 32'd0);
      write_reg(REG_SEC_SEED, s);
      write_reg(REG_SKIP_SEED, s);
    end else if (sel == 1) begin
      // marker on the next second-generator value
      write_reg(REG_SKIP_SEED, lcg_sec * mul_sec + inc_sec);
    end
  endtask

  // receiver back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $error("result beat with no pair expected");
        fail_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_real_fraction !== want.re) begin
          $error("real_fraction: expected %h, actual %h", want.re, out_real_fraction);
          fail_count++;
        end
        if (out_imag_fraction !== want.im) begin
          $error("imag_fraction: expected %h, actual %h", want.im, out_imag_fraction);
          fail_count++;
        end
        if (out_last_out !== want.last) begin
          $error("last_out: expected %b, actual %b", want.last, out_last_out);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("combined_lcg_uniform_random test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    pair_t     lp;
    logic      prev_item;
    int        vec_left;
    logic      last;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_last_of_vector = 1'b0;

    gen_kind  = KIND_COMBINED;
    mul_main  = RST_MAIN_MUL;
    inc_main  = RST_MAIN_INC;
    mul_sec   = RST_SEC_MUL;
    inc_sec   = RST_SEC_INC;
    lcg_main  = RST_MAIN_SEED;
    lcg_sec   = RST_SEC_SEED;
    skip_mark = RST_SKIP_SEED;

    // straight out of reset
    add_item(1'b0, 1'b0, '0, '0);
    add_item(1'b1, 1'b0, '0, '0);
    // single mode, zero multiplier: output is the increment
    add_cfg(REG_KIND, WORD_W'(KIND_SINGLE));
    add_cfg(REG_MAIN_MUL, 32'd0);
    add_cfg(REG_MAIN_INC, 32'hFFFF_FFFF);
    add_item(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cfg(REG_MAIN_INC, 32'd0);
    add_item(1'b0, 1'b1, 32'd0, 32'd0);
    // counter wrapping through zero
    add_cfg(REG_MAIN_MUL, 32'd1);
    add_cfg(REG_MAIN_INC, 32'd1);
    add_cfg(REG_MAIN_SEED, 32'hFFFF_FFFF);
    add_item(1'b1, 1'b1, 32'd0, 32'd1);
    // combined mode, constant generators
    add_cfg(REG_KIND, WORD_W'(KIND_COMBINED));
    add_cfg(REG_MAIN_MUL, 32'd0);
    add_cfg(REG_MAIN_INC, 32'hFFFF_FFFF);
    add_cfg(REG_SEC_MUL, 32'd0);
    add_cfg(REG_SEC_INC, 32'd0);
    add_item(1'b1, 1'b1, 32'hFFFF_FF00, 32'hFFFF_FF00);
    add_cfg(REG_MAIN_INC, 32'd0);
    add_item(1'b0, 1'b1, 32'h0000_0100, 32'h0000_0100);
    // second generator sitting on the marker
    add_cfg(REG_MAIN_MUL, 32'd1);
    add_cfg(REG_MAIN_INC, 32'h0100_0000);
    add_cfg(REG_SEC_MUL, 32'd1);
    add_cfg(REG_SEC_INC, 32'd0);
    add_cfg(REG_SEC_SEED, 32'h8000_0000);
    add_cfg(REG_SKIP_SEED, 32'h8000_0000);
    add_item(1'b0, 1'b0, '0, '0);
    add_item(1'b1, 1'b0, '0, '0);
    // marker wrapping past all ones
    add_cfg(REG_SEC_SEED, 32'hFFFF_FFFF);
    add_cfg(REG_SKIP_SEED, 32'hFFFF_FFFF);
    add_item(1'b1, 1'b0, '0, '0);
    // single mode leaves the second generator alone; state carries over
    add_cfg(REG_KIND, WORD_W'(KIND_SINGLE));
    add_item(1'b0, 1'b0, '0, '0);
    add_cfg(REG_KIND, WORD_W'(KIND_COMBINED));
    add_item(1'b1, 1'b0, '0, '0);
    // all-ones multipliers and increments
    add_cfg(REG_MAIN_MUL, 32'hFFFF_FFFF);
    add_cfg(REG_MAIN_INC, 32'hFFFF_FFFF);
    add_cfg(REG_SEC_MUL, 32'hFFFF_FFFF);
    add_cfg(REG_SEC_INC, 32'hFFFF_FFFF);
    add_cfg(REG_MAIN_SEED, 32'h1234_5678);
    add_cfg(REG_SEC_SEED, 32'd0);
    add_cfg(REG_SKIP_SEED, 32'hFFFF_FFFF);
    add_item(1'b0, 1'b0, '0, '0);
    add_item(1'b0, 1'b0, '0, '0);
    add_item(1'b1, 1'b0, '0, '0);
    // back to the power-up settings
    add_cfg(REG_MAIN_MUL, RST_MAIN_MUL);
    add_cfg(REG_MAIN_INC, RST_MAIN_INC);
    add_cfg(REG_SEC_MUL, RST_SEC_MUL);
    add_cfg(REG_SEC_INC, RST_SEC_INC);
    add_cfg(REG_MAIN_SEED, RST_MAIN_SEED);
    add_cfg(REG_SEC_SEED, RST_SEC_SEED);
    add_cfg(REG_SKIP_SEED, RST_SKIP_SEED);
    add_item(1'b0, 1'b0, '0, '0);
    add_item(1'b1, 1'b0, '0, '0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 51;
    prev_item = 1'b0;
    foreach (directed_rows[k]) begin
      r = directed_rows[k];
      if (r.kind == ROW_CFG) begin
        if (prev_item) wait_drained();
        write_reg(r.idx, r.data);
        prev_item = 1'b0;
      end else begin
        lp.re   = r.re;
        lp.im   = r.im;
        lp.last = r.last;
        send_item(r.last, r.lit, lp);
        prev_item = 1'b1;
      end
    end

    vec_left = 0;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 6) begin
        send_idle_pct = 36;
        recv_idle_pct = 51;
      end else if (seg < 12) begin
        send_idle_pct = 51;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (seg == 3 && n == SEG_ITEMS / 2) wait_drained();
        if (vec_left == 0) vec_left = $urandom_range(1, 8);
        last = (vec_left == 1);
        // occasional random redraw of the flag, in the middle or at the end of a vector
        if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
        vec_left--;
        send_item(last, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("combined_lcg_uniform_random test passed");
    end else begin
      $display("combined_lcg_uniform_random test failed");
    end
    $finish;
  end

endmodule

@@ combined_lcg_uniform_random.f @@
hdl/clug_pkg.sv
hdl/clug_mul_unit.sv
hdl/combined_lcg_uniform_random.sv
tb/sv/tb_top.sv
